// ===== rtl/weighted_chi_square_kahan_core_macros.svh =====
// assertion macros shared by the checker
`ifndef WEIGHTED_CHI_SQUARE_KAHAN_CORE_MACROS_SVH
`define WEIGHTED_CHI_SQUARE_KAHAN_CORE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define WCS_ASSERT_NOW(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define WCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wcs_pkg.sv =====
// shared types, constants and floating point helpers for the chi-square core
package wcs_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [63:0] NEG_INF_BITS  = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] QNAN_BITS     = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] NEG_HALF_BITS = 64'hBFE0_0000_0000_0000;
    localparam logic [10:0] EXP_ONES      = 11'h7FF;

    typedef struct packed {
        logic [63:0] synth;
        logic [63:0] observed;
        logic [63:0] weight;
        logic        last;
        logic        synth_ok;
    } item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } fu_req_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIFF,
        BK_SQ,
        BK_WT,
        BK_ADJ,
        BK_SUM,
        BK_CDIF,
        BK_COMP,
        BK_FIN,
        BK_HALF,
        BK_OUT
    } back_state_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_PP0,
        MS_PP1,
        MS_PP2,
        MS_PP3,
        MS_NORM,
        MS_ALIGN,
        MS_RND
    } mul_step_t;

    function automatic logic is_finite(input logic [63:0] x);
        return x[62:52] != EXP_ONES;
    endfunction

    function automatic logic [63:0] neg(input logic [63:0] x);
        return {~x[63], x[62:0]};
    endfunction

    // shift right keeping the or of lost bits in bit 0
    function automatic logic [55:0] shr_sticky(input logic [55:0] n, input logic [5:0] sh);
        logic [111:0] t;
        t = {n, 56'd0} >> sh;
        return {t[111:57], t[56] | (|t[55:0])};
    endfunction

    function automatic logic [5:0] lzc56(input logic [55:0] v);
        logic [5:0] c;
        logic       found;
        c = 6'd56;
        found = 1'b0;
        for (int i = 55; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                c = 6'(55 - i);
                found = 1'b1;
            end
        end
        return c;
    endfunction

    function automatic logic [6:0] lzc106(input logic [105:0] v);
        logic [6:0] c;
        logic       found;
        c = 7'd106;
        found = 1'b0;
        for (int i = 105; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                c = 7'(105 - i);
                found = 1'b1;
            end
        end
        return c;
    endfunction

    // n: hidden bit at 55, lsb at 3, guard, round, sticky; e >= 1
    function automatic logic [63:0] round_pack(input logic sgn, input logic signed [13:0] e,
                                              input logic [55:0] n);
        logic              inc;
        logic [53:0]       r;
        logic [52:0]       m;
        logic signed [13:0] ef;
        logic [10:0]       fld;
        inc = n[2] & (n[1] | n[0] | n[3]);
        r = {1'b0, n[55:3]} + {53'd0, inc};
        if (r[53])
        begin
            m = r[53:1];
            ef = e + 14'sd1;
        end
        else
        begin
            m = r[52:0];
            ef = e;
        end
        fld = m[52] ? ef[10:0] : 11'd0;
        if (ef >= 14'sd2047)
            return {sgn, EXP_ONES, 52'd0};
        return {sgn, fld, m[51:0]};
    endfunction

endpackage

// ===== rtl/wcs_front.sv =====
// input queue: takes beats, marks non-finite synthetic samples, feeds the sequencer
module wcs_front #(
    parameter int DEPTH = wcs_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [63:0]    synth_bits,
    input  logic [63:0]    observed_bits,
    input  logic [63:0]    weight_bits,
    input  logic           last_sample,
    output logic           q_valid,
    output wcs_pkg::item_t q_item,
    input  logic           q_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wcs_pkg::item_t mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           push;
    wcs_pkg::item_t new_item;

    assign in_stall = (cnt_reg == CW'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem[rd_ptr_reg];

    always_comb
    begin
        new_item.synth    = synth_bits;
        new_item.observed = observed_bits;
        new_item.weight   = weight_bits;
        new_item.last     = last_sample;
        new_item.synth_ok = wcs_pkg::is_finite(synth_bits);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (q_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !q_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && q_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= new_item;
    end

endmodule

// ===== rtl/wcs_fadd.sv =====
// double precision adder, three register stages, round to nearest even
module wcs_fadd (
    input  logic             clk,
    input  logic             rst_n,
    input  wcs_pkg::fu_req_t req,
    output logic             done,
    output logic [63:0]      res
);

    logic [2:0]  v_reg;
    // stage 1: aligned operands
    logic [55:0] s1_a_reg, s1_b_reg;
    logic [10:0] s1_e_reg;
    logic        s1_sub_reg, s1_sgn_reg, s1_spec_reg;
    // stage 2: raw sum
    logic [56:0] s2_s_reg;
    logic [10:0] s2_e_reg;
    logic        s2_sgn_reg, s2_spec_reg;
    // stage 3: normalized
    logic [55:0] s3_n_reg;
    logic [11:0] s3_e_reg;
    logic        s3_sgn_reg, s3_spec_reg;

    logic        swap;
    logic [63:0] x, y;
    logic [52:0] mx, my;
    logic [10:0] ex, ey, dexp;
    logic [5:0]  sh;
    logic [56:0] sum;
    logic [5:0]  lz, kk;
    logic [10:0] lim;
    logic [55:0] n_norm;
    logic [11:0] e_norm;

    always_comb
    begin
        swap = req.b[62:0] > req.a[62:0];
        x    = swap ? req.b : req.a;
        y    = swap ? req.a : req.b;
        mx   = {|x[62:52], x[51:0]};
        my   = {|y[62:52], y[51:0]};
        ex   = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
        ey   = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];
        dexp = ex - ey;
        sh   = (dexp > 11'd63) ? 6'd63 : dexp[5:0];
    end

    always_comb
    begin
        if (s1_sub_reg)
            sum = {1'b0, s1_a_reg} - {1'b0, s1_b_reg};
        else
            sum = {1'b0, s1_a_reg} + {1'b0, s1_b_reg};
    end

    always_comb
    begin
        lz  = wcs_pkg::lzc56(s2_s_reg[55:0]);
        lim = s2_e_reg - 11'd1;
        kk  = ({5'd0, lz} > lim) ? lim[5:0] : lz;
        if (s2_s_reg[56])
        begin
            n_norm = {s2_s_reg[56:2], s2_s_reg[1] | s2_s_reg[0]};
            e_norm = {1'b0, s2_e_reg} + 12'd1;
        end
        else
        begin
            n_norm = s2_s_reg[55:0] << kk;
            e_norm = {1'b0, s2_e_reg} - {6'd0, kk};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[1:0], req.start};
    end

    always_ff @(posedge clk)
    begin
        s1_a_reg    <= {mx, 3'b000};
        s1_b_reg    <= wcs_pkg::shr_sticky({my, 3'b000}, sh);
        s1_e_reg    <= ex;
        s1_sub_reg  <= x[63] ^ y[63];
        s1_sgn_reg  <= x[63];
        s1_spec_reg <= (req.a[62:52] == wcs_pkg::EXP_ONES) || (req.b[62:52] == wcs_pkg::EXP_ONES);

        s2_s_reg    <= sum;
        s2_e_reg    <= s1_e_reg;
        // exact cancellation gives +0
        s2_sgn_reg  <= (s1_sub_reg && sum == 57'd0) ? 1'b0 : s1_sgn_reg;
        s2_spec_reg <= s1_spec_reg;

        s3_n_reg    <= n_norm;
        s3_e_reg    <= e_norm;
        s3_sgn_reg  <= s2_sgn_reg;
        s3_spec_reg <= s2_spec_reg;
    end

    assign done = v_reg[2];
    assign res  = s3_spec_reg ? wcs_pkg::QNAN_BITS
                : wcs_pkg::round_pack(s3_sgn_reg, $signed({2'b00, s3_e_reg}), s3_n_reg);

endmodule

// ===== rtl/wcs_fmul.sv =====
// double precision multiplier, four 27x27 partial products then normalize and round
module wcs_fmul (
    input  logic             clk,
    input  logic             rst_n,
    input  wcs_pkg::fu_req_t req,
    output logic             done,
    output logic [63:0]      res
);

    wcs_pkg::mul_step_t step_reg, step_next;

    logic [52:0]        ma_reg, mb_reg;
    logic [10:0]        ea_reg, eb_reg;
    logic               sgn_reg, spec_reg;
    logic [105:0]       acc_reg;
    logic [105:0]       sh_reg;
    logic signed [13:0] e_reg;
    logic [55:0]        n_reg;

    logic [26:0]        pa, pb;
    logic [6:0]         pshift;
    logic [53:0]        prod;
    logic [6:0]         lz;
    logic [55:0]        n_raw;
    logic signed [13:0] amt;
    logic [5:0]         amt_cap;

    always_comb
    begin
        step_next = step_reg;
        case (step_reg)
            wcs_pkg::MS_IDLE:  if (req.start) step_next = wcs_pkg::MS_PP0;
            wcs_pkg::MS_PP0:   step_next = wcs_pkg::MS_PP1;
            wcs_pkg::MS_PP1:   step_next = wcs_pkg::MS_PP2;
            wcs_pkg::MS_PP2:   step_next = wcs_pkg::MS_PP3;
            wcs_pkg::MS_PP3:   step_next = wcs_pkg::MS_NORM;
            wcs_pkg::MS_NORM:  step_next = wcs_pkg::MS_ALIGN;
            wcs_pkg::MS_ALIGN: step_next = wcs_pkg::MS_RND;
            wcs_pkg::MS_RND:   step_next = wcs_pkg::MS_IDLE;
            default:           step_next = wcs_pkg::MS_IDLE;
        endcase
    end

    always_comb
    begin
        pa     = ma_reg[26:0];
        pb     = mb_reg[26:0];
        pshift = 7'd0;
        case (step_reg)
            wcs_pkg::MS_PP1:
            begin
                pb     = {1'b0, mb_reg[52:27]};
                pshift = 7'd27;
            end
            wcs_pkg::MS_PP2:
            begin
                pa     = {1'b0, ma_reg[52:27]};
                pshift = 7'd27;
            end
            wcs_pkg::MS_PP3:
            begin
                pa     = {1'b0, ma_reg[52:27]};
                pb     = {1'b0, mb_reg[52:27]};
                pshift = 7'd54;
            end
            default:
            begin
                pa     = ma_reg[26:0];
                pb     = mb_reg[26:0];
                pshift = 7'd0;
            end
        endcase
        prod = pa * pb;
    end

    always_comb
    begin
        lz      = wcs_pkg::lzc106(acc_reg);
        n_raw   = {sh_reg[105:51], |sh_reg[50:0]};
        amt     = 14'sd1 - e_reg;
        amt_cap = (amt > 14'sd63) ? 6'd63 : amt[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= wcs_pkg::MS_IDLE;
        else
            step_reg <= step_next;
    end

    always_ff @(posedge clk)
    begin
        case (step_reg)
            wcs_pkg::MS_IDLE:
            begin
                ma_reg   <= {|req.a[62:52], req.a[51:0]};
                mb_reg   <= {|req.b[62:52], req.b[51:0]};
                ea_reg   <= (req.a[62:52] == 11'd0) ? 11'd1 : req.a[62:52];
                eb_reg   <= (req.b[62:52] == 11'd0) ? 11'd1 : req.b[62:52];
                sgn_reg  <= req.a[63] ^ req.b[63];
                spec_reg <= (req.a[62:52] == wcs_pkg::EXP_ONES)
                         || (req.b[62:52] == wcs_pkg::EXP_ONES);
                acc_reg  <= '0;
            end
            wcs_pkg::MS_PP0, wcs_pkg::MS_PP1, wcs_pkg::MS_PP2, wcs_pkg::MS_PP3:
                acc_reg <= acc_reg + (106'(prod) << pshift);
            wcs_pkg::MS_NORM:
            begin
                sh_reg <= acc_reg << lz;
                e_reg  <= $signed({3'b000, ea_reg}) + $signed({3'b000, eb_reg})
                        - 14'sd1022 - $signed({7'd0, lz});
            end
            wcs_pkg::MS_ALIGN:
            begin
                // below the normal range: denormalize before rounding
                if (e_reg < 14'sd1)
                begin
                    n_reg <= wcs_pkg::shr_sticky(n_raw, amt_cap);
                    e_reg <= 14'sd1;
                end
                else
                    n_reg <= n_raw;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign done = (step_reg == wcs_pkg::MS_RND);
    assign res  = spec_reg ? wcs_pkg::QNAN_BITS : wcs_pkg::round_pack(sgn_reg, e_reg, n_reg);

endmodule

// ===== rtl/wcs_back.sv =====
// sequencer: kahan update through the shared adder and multiplier, result register
module wcs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  wcs_pkg::item_t   q_item,
    output logic             q_pop,
    output wcs_pkg::fu_req_t add_req,
    input  logic             add_done,
    input  logic [63:0]      add_res,
    output wcs_pkg::fu_req_t mul_req,
    input  logic             mul_done,
    input  logic [63:0]      mul_res,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [63:0]      loglike_bits,
    output logic             error_flag
);

    wcs_pkg::back_state_t state_reg, state_next;

    logic           wait_reg;
    wcs_pkg::item_t item_reg;
    logic [63:0]    sum_reg, comp_reg, t0_reg, term_reg, adj_reg, nxt_reg;
    logic           err_reg;
    logic           outv_reg;
    logic [63:0]    outd_reg;
    logic           oute_reg;

    logic           fu_done;
    logic [63:0]    fu_res;
    logic           out_load;

    assign fu_done = add_done | mul_done;
    assign fu_res  = mul_done ? mul_res : add_res;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wcs_pkg::BK_IDLE:
                if (q_valid)
                    state_next = (err_reg || !q_item.synth_ok) ? wcs_pkg::BK_FIN : wcs_pkg::BK_DIFF;
            wcs_pkg::BK_DIFF: if (fu_done) state_next = wcs_pkg::BK_SQ;
            wcs_pkg::BK_SQ:   if (fu_done) state_next = wcs_pkg::BK_WT;
            wcs_pkg::BK_WT:
                if (fu_done)
                    state_next = wcs_pkg::is_finite(fu_res) ? wcs_pkg::BK_ADJ : wcs_pkg::BK_FIN;
            wcs_pkg::BK_ADJ:  if (fu_done) state_next = wcs_pkg::BK_SUM;
            wcs_pkg::BK_SUM:
                if (fu_done)
                    state_next = wcs_pkg::is_finite(fu_res) ? wcs_pkg::BK_CDIF : wcs_pkg::BK_FIN;
            wcs_pkg::BK_CDIF: if (fu_done) state_next = wcs_pkg::BK_COMP;
            wcs_pkg::BK_COMP: if (fu_done) state_next = wcs_pkg::BK_FIN;
            wcs_pkg::BK_FIN:
                if (!item_reg.last)
                    state_next = wcs_pkg::BK_IDLE;
                else
                    state_next = err_reg ? wcs_pkg::BK_OUT : wcs_pkg::BK_HALF;
            wcs_pkg::BK_HALF: if (fu_done) state_next = wcs_pkg::BK_OUT;
            wcs_pkg::BK_OUT:
                if (!outv_reg || !out_stall)
                    state_next = wcs_pkg::BK_IDLE;
            default:          state_next = wcs_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop         = 1'b0;
        add_req.start = 1'b0;
        add_req.a     = item_reg.synth;
        add_req.b     = wcs_pkg::neg(item_reg.observed);
        mul_req.start = 1'b0;
        mul_req.a     = t0_reg;
        mul_req.b     = t0_reg;
        out_load      = 1'b0;
        case (state_reg)
            wcs_pkg::BK_IDLE: q_pop = q_valid;
            wcs_pkg::BK_DIFF: add_req.start = !wait_reg;
            wcs_pkg::BK_SQ:   mul_req.start = !wait_reg;
            wcs_pkg::BK_WT:
            begin
                mul_req.start = !wait_reg;
                mul_req.a     = term_reg;
                mul_req.b     = item_reg.weight;
            end
            wcs_pkg::BK_ADJ:
            begin
                add_req.start = !wait_reg;
                add_req.a     = term_reg;
                add_req.b     = wcs_pkg::neg(comp_reg);
            end
            wcs_pkg::BK_SUM:
            begin
                add_req.start = !wait_reg;
                add_req.a     = sum_reg;
                add_req.b     = adj_reg;
            end
            wcs_pkg::BK_CDIF:
            begin
                add_req.start = !wait_reg;
                add_req.a     = nxt_reg;
                add_req.b     = wcs_pkg::neg(sum_reg);
            end
            wcs_pkg::BK_COMP:
            begin
                add_req.start = !wait_reg;
                add_req.a     = t0_reg;
                add_req.b     = wcs_pkg::neg(adj_reg);
            end
            wcs_pkg::BK_HALF:
            begin
                mul_req.start = !wait_reg;
                mul_req.a     = wcs_pkg::NEG_HALF_BITS;
                mul_req.b     = sum_reg;
            end
            wcs_pkg::BK_OUT:  out_load = !outv_reg || !out_stall;
            default:          q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wcs_pkg::BK_IDLE;
            wait_reg  <= 1'b0;
            sum_reg   <= '0;
            comp_reg  <= '0;
            err_reg   <= 1'b0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fu_done)
                wait_reg <= 1'b0;
            else if (add_req.start || mul_req.start)
                wait_reg <= 1'b1;

            if (q_pop && !q_item.synth_ok)
                err_reg <= 1'b1;
            if (fu_done && (state_reg == wcs_pkg::BK_WT || state_reg == wcs_pkg::BK_SUM)
                && !wcs_pkg::is_finite(fu_res))
                err_reg <= 1'b1;
            if (fu_done && state_reg == wcs_pkg::BK_COMP)
            begin
                comp_reg <= fu_res;
                sum_reg  <= nxt_reg;
            end

            if (out_load)
            begin
                outv_reg <= 1'b1;
                sum_reg  <= '0;
                comp_reg <= '0;
                err_reg  <= 1'b0;
            end
            else if (outv_reg && !out_stall)
                outv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_item;
        if (fu_done)
        begin
            case (state_reg)
                wcs_pkg::BK_DIFF: t0_reg   <= fu_res;
                wcs_pkg::BK_SQ:   term_reg <= fu_res;
                wcs_pkg::BK_WT:   term_reg <= fu_res;
                wcs_pkg::BK_ADJ:  adj_reg  <= fu_res;
                wcs_pkg::BK_SUM:  nxt_reg  <= fu_res;
                wcs_pkg::BK_CDIF: t0_reg   <= fu_res;
                wcs_pkg::BK_HALF: t0_reg   <= fu_res;
                default:          t0_reg   <= t0_reg;
            endcase
        end
        if (out_load)
        begin
            outd_reg <= err_reg ? wcs_pkg::NEG_INF_BITS : t0_reg;
            oute_reg <= err_reg;
        end
    end

    assign out_valid    = outv_reg;
    assign loglike_bits = outd_reg;
    assign error_flag   = oute_reg;

endmodule

// ===== rtl/weighted_chi_square_kahan_core.sv =====
// top level of the weighted chi-square accumulator with kahan compensation
//
// input channel: in_valid / in_stall carry one sample beat (synth_bits, observed_bits,
// weight_bits as ieee doubles, last_sample). a beat is taken when in_valid is high and
// in_stall is low. beats land in a small queue, so the sender keeps going while the
// sequencer works or while a result waits on the output.
// output channel: out_valid / out_stall carry one beat per run, on the beat marked
// last_sample: loglike_bits = -0.5 * sum of weighted squared differences, or minus
// infinity with error_flag set when a non-finite value showed up in the run.
// flow: a beat waits in the queue until the sequencer pops it; one sample then runs
// through the sequencer as a chain of five additions and two multiplies through one
// shared adder and one shared multiplier, plus a pop state and a finish state; a sample
// after an error goes straight from the pop state to the finish state. after the last
// sample finishes its update, the result passes the finish state, the halving multiply
// (skipped after an error) and the output load.
// reset: queue empties, sum and compensation go to +0.0, error latch clears.
// a stalled output holds its beat; the sequencer waits for the output register to free
// up before it retires the next run, and the queue fills and raises in_stall.
module weighted_chi_square_kahan_core #(
    parameter int QUEUE_DEPTH = wcs_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] synth_bits,
    input  logic [63:0] observed_bits,
    input  logic [63:0] weight_bits,
    input  logic        last_sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] loglike_bits,
    output logic        error_flag
);

    logic             q_valid;
    wcs_pkg::item_t   q_item;
    logic             q_pop;
    wcs_pkg::fu_req_t add_req, mul_req;
    logic             add_done, mul_done;
    logic [63:0]      add_res, mul_res;

    wcs_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .synth_bits   (synth_bits),
        .observed_bits(observed_bits),
        .weight_bits  (weight_bits),
        .last_sample  (last_sample),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    wcs_fadd u_fadd (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (add_req),
        .done (add_done),
        .res  (add_res)
    );

    wcs_fmul u_fmul (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mul_req),
        .done (mul_done),
        .res  (mul_res)
    );

    wcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .add_req     (add_req),
        .add_done    (add_done),
        .add_res     (add_res),
        .mul_req     (mul_req),
        .mul_done    (mul_done),
        .mul_res     (mul_res),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .loglike_bits(loglike_bits),
        .error_flag  (error_flag)
    );

endmodule

// ===== rtl/wcs_checker.sv =====
// port-level checks on the chi-square core, bound to the top level
`include "weighted_chi_square_kahan_core_macros.svh"

module wcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] loglike_bits,
    input logic        error_flag
);

    `WCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(loglike_bits) && $stable(error_flag), "stalled result beat changed")
    `WCS_ASSERT_NOW(a_err_value, !(out_valid && error_flag) || loglike_bits == wcs_pkg::NEG_INF_BITS, "error beat without minus infinity")
    `WCS_ASSERT_NOW(a_ok_finite, !(out_valid && !error_flag) || loglike_bits[62:52] != wcs_pkg::EXP_ONES, "clean beat is not finite")

endmodule

bind weighted_chi_square_kahan_core wcs_checker u_wcs_checker (.*);

// ===== dv/weighted_chi_square_kahan_core_test.sv =====
// testbench for the weighted chi-square accumulator with kahan compensation
`timescale 1ns / 100ps

module weighted_chi_square_kahan_core_test;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_LEN = 600;

    typedef struct packed {
        logic [63:0] loglike;
        logic        error;
    } run_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] synth_bits;
    logic [63:0] observed_bits;
    logic [63:0] weight_bits;
    logic        last_sample;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] loglike_bits;
    logic        error_flag;

    // predicted run state
    real         chi_sum;
    real         chi_comp;
    logic        run_failed;
    run_result_t pending_loglike[$];

    int          send_gap_pct;
    int          stall_pct;
    int          hold_requests = 0;
    int          hold_seen = 0;
    int          hold_cycles = 0;
    int          mismatches = 0;
    int          cycles = 0;

    weighted_chi_square_kahan_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .synth_bits   (synth_bits),
        .observed_bits(observed_bits),
        .weight_bits  (weight_bits),
        .last_sample  (last_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .loglike_bits (loglike_bits),
        .error_flag   (error_flag)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic finite_bits(input logic [63:0] x);
        return x[62:52] != wcs_pkg::EXP_ONES;
    endfunction

    function automatic void clear_run();
        chi_sum = 0.0;
        chi_comp = 0.0;
        run_failed = 1'b0;
    endfunction

    // kahan update of the predicted sum for one accepted beat
    function automatic void predict_sample(input logic [63:0] s, input logic [63:0] o,
                                           input logic [63:0] w, input logic l);
        real         diff;
        real         term;
        real         adj;
        real         nxt;
        run_result_t res;
        if (!run_failed)
        begin
            if (!finite_bits(s))
                run_failed = 1'b1;
            else
            begin
                diff = $bitstoreal(s) - $bitstoreal(o);
                term = diff * diff;
                term = term * $bitstoreal(w);
                if (!finite_bits($realtobits(term)))
                    run_failed = 1'b1;
                else
                begin
                    adj = term - chi_comp;
                    nxt = chi_sum + adj;
                    if (!finite_bits($realtobits(nxt)))
                        run_failed = 1'b1;
                    else
                    begin
                        diff = nxt - chi_sum;
                        chi_comp = diff - adj;
                        chi_sum = nxt;
                    end
                end
            end
        end
        if (l)
        begin
            if (run_failed)
                res = '{loglike: wcs_pkg::NEG_INF_BITS, error: 1'b1};
            else
                res = '{loglike: $realtobits(-0.5 * chi_sum), error: 1'b0};
            pending_loglike.push_back(res);
            clear_run();
        end
    endfunction

    function automatic logic [63:0] random_double();
        logic [63:0] b;
        int          pick;
        b = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 2)
            return b;
        else if (pick < 3)
            return {b[63], wcs_pkg::EXP_ONES, b[51:0]};
        else if (pick < 5)
            return {b[63], 63'd0};
        else if (pick < 7)
            return {b[63], 11'd0, b[51:0]};
        return {b[63], 11'(1023 - 20 + $urandom_range(0, 40)), b[51:0]};
    endfunction

    task automatic send_sample(input logic [63:0] s, input logic [63:0] o,
                               input logic [63:0] w, input logic l);
        // idle cycles come one at a time with the given percentage
        while (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        synth_bits <= s;
        observed_bits <= o;
        weight_bits <= w;
        last_sample <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_sample(s, o, w, l);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_loglike.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        logic [63:0] one;
        logic [63:0] big;
        one = 64'h3FF0_0000_0000_0000;
        big = 64'h7FEF_FFFF_FFFF_FFFF;
        // single beat run gives minus zero
        send_sample(one, one, one, 1'b1);
        send_sample(64'h4000_0000_0000_0000, one, 64'h4010_0000_0000_0000, 1'b0);
        send_sample(64'h8000_0000_0000_0000, 64'h0, 64'h0, 1'b0);
        send_sample(64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF, one, 1'b1);
        // non-finite synth, later beats ignored up to last
        send_sample(wcs_pkg::NEG_INF_BITS, one, one, 1'b0);
        send_sample(one, 64'h0, one, 1'b1);
        send_sample(wcs_pkg::QNAN_BITS, one, one, 1'b1);
        send_sample(one, 64'hFFFF_FFFF_FFFF_FFFF, one, 1'b1);
        send_sample(one, 64'h0, 64'h7FF0_0000_0000_0000, 1'b1);
        // difference overflow, then weighted term overflow from a large weight
        send_sample(big, 64'hFFEF_FFFF_FFFF_FFFF, one, 1'b1);
        send_sample(64'h5FE0_0000_0000_0000, 64'h0, big, 1'b0);
        send_sample(64'h5FE0_0000_0000_0000, 64'h0, big, 1'b1);
        // negative weight and cancellation
        send_sample(64'h4059_0000_0000_0000, one, 64'hBFF0_0000_0000_0000, 1'b0);
        send_sample(64'h3CB0_0000_0000_0000, 64'h0, one, 1'b0);
        send_sample(64'h4059_0000_0000_0000, one, one, 1'b1);
        // state cleared after end of run
        send_sample(one, 64'h0, one, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_runs(input int n_items);
        int sent;
        int run_len;
        sent = 0;
        while (sent < n_items)
        begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                  : $urandom_range(1, 12);
            for (int i = 0; i < run_len; i++)
                send_sample(random_double(), random_double(), random_double(),
                            i == run_len - 1);
            sent += run_len;
        end
    endtask

    task automatic test_output_backpressure();
        hold_requests++;
        for (int i = 0; i < 12; i++)
            send_sample(random_double(), random_double(), random_double(), 1'b1);
        wait_drained();
    endtask

    // receiver side stall, long holds counted here
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_cycles <= HOLD_LEN - 1;
            out_stall <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        run_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_loglike.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: loglike %h error %b",
                             loglike_bits, error_flag);
            end
            else
            begin
                exp_res = pending_loglike.pop_front();
                if (loglike_bits !== exp_res.loglike || error_flag !== exp_res.error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: loglike exp %h got %h, error exp %b got %b",
                                 exp_res.loglike, loglike_bits, exp_res.error, error_flag);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        synth_bits = '0;
        observed_bits = '0;
        weight_bits = '0;
        last_sample = 1'b0;
        send_gap_pct = 0;
        stall_pct = 0;
        clear_run();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        send_gap_pct = 6;
        stall_pct = 75;
        test_random_runs(280);
        test_output_backpressure();
        send_gap_pct = 75;
        stall_pct = 6;
        test_random_runs(280);
        wait_drained();
        send_gap_pct = 0;
        stall_pct = 0;
        test_random_runs(280);
        wait_drained();

        if (mismatches == 0 && pending_loglike.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
